// File: sv/slpg_pkg.sv
// shared types and constants of the status led pattern generator
`timescale 1ns / 1ps

package slpg_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int TIME_W      = 32;
    localparam int PERIOD_W    = 16;
    localparam int NTH_W       = 8;
    localparam int COLOR_W     = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLIP_NTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_DISC     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_BLIP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_STARTUP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_LOST     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_NO_MAG   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_OK       = 3'd7;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd1000;
    localparam logic [NTH_W-1:0]    BLIP_NTH_RST     = 8'd10;

    typedef enum logic [2:0] {
        MODE_DISCOVERY = 3'd0,
        MODE_BLIP      = 3'd1,
        MODE_WAITING   = 3'd2,
        MODE_LOST      = 3'd3,
        MODE_NO_MAGNET = 3'd4,
        MODE_POSITIVE  = 3'd5,
        MODE_NEGATIVE  = 3'd6,
        MODE_IDLE      = 3'd7
    } led_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PULSE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] blink_period_ms;
        logic [NTH_W-1:0]    blip_every_nth;
        logic [COLOR_W-1:0]  color_discovery;
        logic [COLOR_W-1:0]  color_blip;
        logic [COLOR_W-1:0]  color_startup;
        logic [COLOR_W-1:0]  color_lost;
        logic [COLOR_W-1:0]  color_no_magnet;
        logic [COLOR_W-1:0]  color_ok;
    } cfg_t;

endpackage

// File: sv/slpg_serial_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module slpg_serial_div #(
    parameter int W  = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] rem,
    output logic [W-1:0]  quo
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [W-1:0]  dq_reg, dq_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW:0]   shifted;
    logic          ge;

    always_comb
    begin
        shifted   = {rem_reg, dq_reg[W-1]};
        ge        = shifted >= {1'b0, div_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            rem_next = '0;
            dq_next  = dividend;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
            rem_next  = ge ? DW'(shifted - {1'b0, div_reg}) : shifted[DW-1:0];
            dq_next   = {dq_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = dq_reg;

endmodule

// File: sv/slpg_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module slpg_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output slpg_pkg::cfg_t                 cfg
);

    import slpg_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLINK_PERIOD: cfg_next.blink_period_ms = cfg_data[PERIOD_W-1:0];
                CFG_BLIP_NTH:     cfg_next.blip_every_nth  = cfg_data[NTH_W-1:0];
                CFG_COL_DISC:     cfg_next.color_discovery = cfg_data[COLOR_W-1:0];
                CFG_COL_BLIP:     cfg_next.color_blip      = cfg_data[COLOR_W-1:0];
                CFG_COL_STARTUP:  cfg_next.color_startup   = cfg_data[COLOR_W-1:0];
                CFG_COL_LOST:     cfg_next.color_lost      = cfg_data[COLOR_W-1:0];
                CFG_COL_NO_MAG:   cfg_next.color_no_magnet = cfg_data[COLOR_W-1:0];
                CFG_COL_OK:       cfg_next.color_ok        = cfg_data[COLOR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // blink period and blip interval first, all colours dark
            cfg_reg <= {BLINK_PERIOD_RST, BLIP_NTH_RST, {6*COLOR_W{1'b0}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/status_led_pattern_generator.sv
// top level of the status led pattern generator
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: one tick with status
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: led colour and mode
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data register write
//
// a new tick is taken only once the last result is loaded: beat count and flash
// cycle use 32-bit serial dividers side by side, while a 16-bit divide of the
// blink period by the speed divisor feeds the 32-bit blink phase divide; the
// flash phase then takes a 16-bit divide by the pulse length for the flash parity;
// both chains finish together
// s_tready is high only while no tick is in work; a finished result sits in the
// output register, so the next tick can be taken while m_tready is low
// reset clears beat count, last stamp and all control state and loads the configuration defaults
`timescale 1ns / 1ps

module status_led_pattern_generator #(
    parameter int FLASH_CYCLE_MS = 3000,
    parameter int FLASH_TOTAL_MS = 600,
    parameter int FLASH_PULSE_MS = 100,
    parameter int BLIP_LENGTH_MS = 100,
    parameter int POS_SPEED_DIV  = 4,
    parameter int NEG_SPEED_DIV  = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], seen_heartbeat[32], master_ok[33], heartbeat_stamp[65:34],
    // motion_sign[67:66], magnet_present[68], discovery_on[69], zero pad
    input  logic [slpg_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // led_red[7:0], led_green[15:8], led_blue[23:16], led_mode[26:24], zero pad
    output logic [slpg_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [slpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import slpg_pkg::*;

    localparam int FDW = 16;
    localparam int SDW = 7;

    cfg_t cfg;

    // input fields
    logic [TIME_W-1:0] in_now;
    logic              in_seen;
    logic              in_alive;
    logic [TIME_W-1:0] in_stamp;
    logic [1:0]        in_sign;
    logic              in_magnet;
    logic              in_disc;

    logic              s_xfer;
    logic              m_xfer;

    state_t state_reg, state_next;
    logic   out_load;
    logic   start_pulse;

    // heartbeat bookkeeping
    logic [TIME_W-1:0] beat_count_reg, beat_count_next;
    logic [TIME_W-1:0] last_stamp_reg;

    // per-tick latched status
    logic              seen_reg, alive_reg, magnet_reg, pos_reg, neg_reg, disc_reg;
    logic              blip_time_reg, count_nz_reg, nth_nz_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SDW-1:0]    speed_sel;
    logic              pos_in, neg_in;

    // divider results
    logic              per_done, beat_done, phase_done, cyc_done, pulse_done;
    logic [SDW-1:0]    per_rem;
    logic [PERIOD_W-1:0] per_quo;
    logic [NTH_W-1:0]  beat_rem;
    logic [PERIOD_W-1:0] phase_rem;
    logic [FDW-1:0]    cyc_rem;
    logic [FDW-1:0]    pulse_rem;
    logic [TIME_W-1:0] beat_quo, phase_quo, cyc_quo;
    logic [FDW-1:0]    pulse_quo;

    // decision
    logic              blip, period_on, waiting_on;
    led_mode_t         mode;
    logic [COLOR_W-1:0] colour;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign in_now    = s_tdata[31:0];
    assign in_seen   = s_tdata[32];
    assign in_alive  = s_tdata[33];
    assign in_stamp  = s_tdata[65:34];
    assign in_sign   = s_tdata[67:66];
    assign in_magnet = s_tdata[68];
    assign in_disc   = s_tdata[69];

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid_reg && m_tready;

    slpg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // new beat counted whenever the stamp moves while a heartbeat was seen
    assign beat_count_next = (in_seen && (in_stamp != last_stamp_reg))
                           ? beat_count_reg + TIME_W'(1) : beat_count_reg;

    assign pos_in = (in_sign == 2'b01);
    assign neg_in = in_sign[1];

    // speed divisor is known from the flags alone; blip only overrides it
    always_comb
    begin
        if (!in_seen || !in_alive || !in_magnet)
            speed_sel = SDW'(1);
        else if (pos_in)
            speed_sel = SDW'(POS_SPEED_DIV);
        else if (neg_in)
            speed_sel = SDW'(NEG_SPEED_DIV);
        else
            speed_sel = SDW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_count_reg <= '0;
            last_stamp_reg <= '0;
        end
        else if (s_xfer)
        begin
            beat_count_reg <= beat_count_next;
            last_stamp_reg <= in_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            seen_reg      <= in_seen;
            alive_reg     <= in_alive;
            magnet_reg    <= in_magnet;
            pos_reg       <= pos_in;
            neg_reg       <= neg_in;
            disc_reg      <= in_disc;
            count_nz_reg  <= (beat_count_next != '0);
            nth_nz_reg    <= (cfg.blip_every_nth != '0);
            blip_time_reg <= (TIME_W'(in_now - in_stamp) < TIME_W'(BLIP_LENGTH_MS));
            now_reg       <= in_now;
        end
    end

    // blink period of the selected mode
    slpg_serial_div #(.W(PERIOD_W), .DW(SDW)) u_per_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_xfer),
        .dividend (cfg.blink_period_ms),
        .divisor  (speed_sel),
        .done     (per_done),
        .rem      (per_rem),
        .quo      (per_quo)
    );

    // beat count modulo blip interval
    slpg_serial_div #(.W(TIME_W), .DW(NTH_W)) u_beat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_xfer),
        .dividend (beat_count_next),
        .divisor  (cfg.blip_every_nth),
        .done     (beat_done),
        .rem      (beat_rem),
        .quo      (beat_quo)
    );

    // blink phase within the selected period, started once the period is known
    slpg_serial_div #(.W(TIME_W), .DW(PERIOD_W)) u_phase_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (per_done),
        .dividend (now_reg),
        .divisor  (per_quo),
        .done     (phase_done),
        .rem      (phase_rem),
        .quo      (phase_quo)
    );

    // position within the flash cycle
    slpg_serial_div #(.W(TIME_W), .DW(FDW)) u_cyc_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_xfer),
        .dividend (in_now),
        .divisor  (FDW'(FLASH_CYCLE_MS)),
        .done     (cyc_done),
        .rem      (cyc_rem),
        .quo      (cyc_quo)
    );

    // pulse number within the flash burst, only its parity matters
    slpg_serial_div #(.W(FDW), .DW(FDW)) u_pulse_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_pulse),
        .dividend (cyc_rem),
        .divisor  (FDW'(FLASH_PULSE_MS)),
        .done     (pulse_done),
        .rem      (pulse_rem),
        .quo      (pulse_quo)
    );

    // sequencer: next state
    // the blink phase chain finishes in the same cycle as the pulse divide
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_DIVIDE;
            ST_DIVIDE: if (cyc_done) state_next = ST_PULSE;
            ST_PULSE:  if (pulse_done) state_next = ST_DONE;
            ST_DONE:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready    = 1'b0;
        start_pulse = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_DIVIDE: start_pulse = cyc_done;
            ST_PULSE:  start_pulse = 1'b0;
            ST_DONE:   out_load = !m_tvalid_reg || m_tready;
            default:   s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // mode and colour from the settled divider results
    assign blip = seen_reg && count_nz_reg && nth_nz_reg && (beat_rem == '0) && blip_time_reg;
    assign period_on = (per_quo != '0) && (phase_rem < (per_quo >> 1));
    assign waiting_on = (cyc_rem < FDW'(FLASH_TOTAL_MS)) ? !pulse_quo[0] : period_on;

    always_comb
    begin
        colour = '0;
        if (disc_reg)
        begin
            mode   = MODE_DISCOVERY;
            colour = cfg.color_discovery;
        end
        else if (blip)
        begin
            mode   = MODE_BLIP;
            colour = cfg.color_blip;
        end
        else if (!seen_reg)
        begin
            mode = MODE_WAITING;
            if (waiting_on) colour = cfg.color_startup;
        end
        else if (!alive_reg)
        begin
            mode = MODE_LOST;
            if (period_on) colour = cfg.color_lost;
        end
        else if (!magnet_reg)
        begin
            mode = MODE_NO_MAGNET;
            if (period_on) colour = cfg.color_no_magnet;
        end
        else if (pos_reg)
        begin
            mode = MODE_POSITIVE;
            if (period_on) colour = cfg.color_ok;
        end
        else if (neg_reg)
        begin
            mode = MODE_NEGATIVE;
            if (period_on) colour = cfg.color_ok;
        end
        else
        begin
            mode = MODE_IDLE;
        end
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_xfer)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {5'b0, mode, colour[7:0], colour[15:8], colour[23:16]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/slpg_checker.sv
// port-level checks of the status led pattern generator, bound to the top level
`timescale 1ns / 1ps

module slpg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [slpg_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [slpg_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import slpg_pkg::*;

    // a tick in work blocks the next one
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in work");

    // ready drops only because a tick was taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without a transfer");

    // idle mode is always dark
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[26:24] == MODE_IDLE) |-> (m_tdata[23:0] == '0))
        else $error("idle mode with a lit colour");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);
